### hdl/rau_pkg.sv
// rau_pkg: shared widths, codes and controller/datapath interface types
package rau_pkg;

  localparam int OPERAND_BITS  = 16;
  localparam int MAG_BITS      = OPERAND_BITS + 1;
  localparam int WIDE_BITS     = 2 * OPERAND_BITS;
  localparam int CNT_BITS      = $clog2(WIDE_BITS);
  localparam int NUM_OUT_BITS  = 33;
  localparam int DEN_OUT_BITS  = 31;
  localparam int KIND_BITS     = 2;
  localparam int IN_DATA_BITS  = ((4 * OPERAND_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((NUM_OUT_BITS + DEN_OUT_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MSTEP_FIRST = 2'd0,
    MSTEP_CROSS = 2'd1,
    MSTEP_DEN   = 2'd2
  } mstep_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_ZERO = 2'd1,
    RES_ERR  = 2'd2
  } res_e;

  typedef struct packed {
    logic   load;
    logic   mul_en;
    mstep_e mul_step;
    logic   sum;
    logic   gcd_init;
    logic   gcd_step;
    logic   div_init;
    logic   div_step;
    logic   out_load;
    res_e   res_sel;
  } rau_cmd_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic gcd_done;
  } rau_status_t;

endpackage

### hdl/rau_datapath.sv
// rau_datapath: operand registers, shared multiplier, binary gcd and dual divider lanes
module rau_datapath import rau_pkg::*; (
  input  logic                           clk_i,
  input  rau_cmd_t                       cmd_i,
  output rau_status_t                    status_o,
  input  logic [KIND_BITS-1:0]           kind_i,
  input  logic [OPERAND_BITS-1:0]        num_a_i,
  input  logic [OPERAND_BITS-1:0]        den_a_i,
  input  logic [OPERAND_BITS-1:0]        num_b_i,
  input  logic [OPERAND_BITS-1:0]        den_b_i,
  output logic signed [NUM_OUT_BITS-1:0] num_out_o,
  output logic [DEN_OUT_BITS-1:0]        den_out_o,
  output logic                           status_out_o
);

  function automatic logic [MAG_BITS-1:0] mag_of(input logic [OPERAND_BITS-1:0] v);
    logic [MAG_BITS-1:0] ext;
    ext = {v[OPERAND_BITS-1], v};
    return v[OPERAND_BITS-1] ? (MAG_BITS'(0) - ext) : ext;
  endfunction

  // one restoring division step, returns {remainder, quotient}
  function automatic logic [2*WIDE_BITS-1:0] div_bit(input logic [WIDE_BITS-1:0] r,
                                                     input logic [WIDE_BITS-1:0] q,
                                                     input logic [WIDE_BITS-1:0] g);
    logic [WIDE_BITS-1:0] sh;
    sh = {r[WIDE_BITS-2:0], q[WIDE_BITS-1]};
    if (sh >= g) begin
      return {sh - g, q[WIDE_BITS-2:0], 1'b1};
    end else begin
      return {sh, q[WIDE_BITS-2:0], 1'b0};
    end
  endfunction

  kind_e                   kind_q;
  logic                    na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
  logic [MAG_BITS-1:0]     na_mag_q, da_mag_q, nb_mag_q, db_mag_q;
  logic [WIDE_BITS-1:0]    t0_q, t1_q, num_mag_q, den_mag_q;
  logic                    t0_neg_q, t1_neg_q, num_neg_q, den_neg_q, res_neg_q;
  logic [WIDE_BITS-1:0]    ga_q, gb_q, g_q;
  logic [CNT_BITS-1:0]     k_q;
  logic [WIDE_BITS-1:0]    rn_q, qn_q, rd_q, qd_q;
  logic signed [NUM_OUT_BITS-1:0] num_out_q;
  logic [DEN_OUT_BITS-1:0] den_out_q;
  logic                    stat_q;

  logic [MAG_BITS-1:0]     ma, mb;
  logic                    mneg;
  logic [2*MAG_BITS-1:0]   prod;
  logic [WIDE_BITS-1:0]    prod_w;
  logic [WIDE_BITS-1:0]    sum_mag;
  logic                    sum_neg;
  logic [2*WIDE_BITS-1:0]  lane_n, lane_d;
  logic [NUM_OUT_BITS-1:0] qn_ext;

  always_comb begin
    unique case (cmd_i.mul_step)
      MSTEP_FIRST: begin
        ma = na_mag_q;
        if (kind_q == KIND_MUL) begin
          mb   = nb_mag_q;
          mneg = na_neg_q ^ nb_neg_q;
        end else begin
          mb   = db_mag_q;
          mneg = na_neg_q ^ db_neg_q;
        end
      end
      MSTEP_CROSS: begin
        ma   = nb_mag_q;
        mb   = da_mag_q;
        mneg = nb_neg_q ^ da_neg_q ^ (kind_q == KIND_SUB);
      end
      MSTEP_DEN: begin
        ma = da_mag_q;
        if (kind_q == KIND_DIV) begin
          mb   = nb_mag_q;
          mneg = da_neg_q ^ nb_neg_q;
        end else begin
          mb   = db_mag_q;
          mneg = da_neg_q ^ db_neg_q;
        end
      end
      default: begin
        ma   = '0;
        mb   = '0;
        mneg = 1'b0;
      end
    endcase
    prod   = ma * mb;
    prod_w = prod[WIDE_BITS-1:0];
  end

  always_comb begin
    if (t0_neg_q == t1_neg_q) begin
      sum_neg = t0_neg_q;
      sum_mag = t0_q + t1_q;
    end else if (t0_q >= t1_q) begin
      sum_neg = t0_neg_q;
      sum_mag = t0_q - t1_q;
    end else begin
      sum_neg = t1_neg_q;
      sum_mag = t1_q - t0_q;
    end
  end

  assign lane_n = div_bit(rn_q, qn_q, g_q);
  assign lane_d = div_bit(rd_q, qd_q, g_q);
  assign qn_ext = NUM_OUT_BITS'(qn_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_e'(kind_i);
      na_neg_q <= num_a_i[OPERAND_BITS-1];
      da_neg_q <= den_a_i[OPERAND_BITS-1];
      nb_neg_q <= num_b_i[OPERAND_BITS-1];
      db_neg_q <= den_b_i[OPERAND_BITS-1];
      na_mag_q <= mag_of(num_a_i);
      da_mag_q <= mag_of(den_a_i);
      nb_mag_q <= mag_of(num_b_i);
      db_mag_q <= mag_of(den_b_i);
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_step)
        MSTEP_FIRST: begin
          t0_q     <= prod_w;
          t0_neg_q <= mneg;
        end
        MSTEP_CROSS: begin
          t1_q     <= prod_w;
          t1_neg_q <= mneg;
        end
        MSTEP_DEN: begin
          den_mag_q <= prod_w;
          den_neg_q <= mneg;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.sum) begin
      if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
        num_mag_q <= sum_mag;
        num_neg_q <= sum_neg;
      end else begin
        num_mag_q <= t0_q;
        num_neg_q <= t0_neg_q;
      end
    end
    if (cmd_i.gcd_init) begin
      ga_q <= num_mag_q;
      gb_q <= den_mag_q;
      k_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      priority if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        k_q  <= k_q + CNT_BITS'(1);
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
    if (cmd_i.div_init) begin
      g_q       <= gb_q << k_q;
      rn_q      <= '0;
      qn_q      <= num_mag_q;
      rd_q      <= '0;
      qd_q      <= den_mag_q;
      res_neg_q <= num_neg_q ^ den_neg_q;
    end else if (cmd_i.div_step) begin
      rn_q <= lane_n[2*WIDE_BITS-1:WIDE_BITS];
      qn_q <= lane_n[WIDE_BITS-1:0];
      rd_q <= lane_d[2*WIDE_BITS-1:WIDE_BITS];
      qd_q <= lane_d[WIDE_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.res_sel)
        RES_OK: begin
          num_out_q <= res_neg_q ? (NUM_OUT_BITS'(0) - qn_ext) : qn_ext;
          den_out_q <= DEN_OUT_BITS'(qd_q);
          stat_q    <= 1'b0;
        end
        RES_ZERO: begin
          num_out_q <= '0;
          den_out_q <= DEN_OUT_BITS'(1);
          stat_q    <= 1'b0;
        end
        default: begin
          num_out_q <= '0;
          den_out_q <= '0;
          stat_q    <= 1'b1;
        end
      endcase
    end
  end

  assign status_o.err      = (da_mag_q == '0) || (db_mag_q == '0) ||
                             ((kind_q == KIND_DIV) && (nb_mag_q == '0));
  assign status_o.num_zero = (num_mag_q == '0);
  assign status_o.gcd_done = (ga_q == '0);

  assign num_out_o    = num_out_q;
  assign den_out_o    = den_out_q;
  assign status_out_o = stat_q;

endmodule

### hdl/rau_ctrl.sv
// rau_ctrl: sequencing state machine and output handshake
module rau_ctrl import rau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  input  rau_status_t status_i,
  output rau_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_MUL0  = 11'b000_0000_0100,
    S_MUL1  = 11'b000_0000_1000,
    S_MUL2  = 11'b000_0001_0000,
    S_SUM   = 11'b000_0010_0000,
    S_TEST  = 11'b000_0100_0000,
    S_GCD   = 11'b000_1000_0000,
    S_DIVI  = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e              state_q, state_d;
  res_e                res_q, res_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.res_sel = res_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.err) begin
          res_d   = RES_ERR;
          state_d = S_DONE;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_FIRST;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_CROSS;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_DEN;
        state_d        = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_TEST;
      end
      S_TEST: begin
        if (status_i.num_zero) begin
          res_d   = RES_ZERO;
          state_d = S_DONE;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (status_i.gcd_done) begin
          state_d = S_DIVI;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        res_d          = RES_OK;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(WIDE_BITS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= RES_OK;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

### hdl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level of the reduced-fraction arithmetic unit
//
// an input item carries an operation in s_axis_tuser_i and two signed fractions
// in s_axis_tdata_i; one result item per input leaves on the m_axis group with
// the reduced numerator and positive denominator in m_axis_tdata_o and an error
// flag in m_axis_tuser_o (zero denominator or divide by zero gives 0/0, flag set)
// one item is worked on at a time: s_axis_tready_o is high only while idle
// an error item goes to its result after the check, a zero result after the
// products, sum and zero test; any other result waits for the binary gcd loop,
// whose step count depends on the operands, and then for the 32-step restoring
// divider that reduces numerator and denominator in parallel
// a finished result sits in the output register; the next item is accepted
// while it waits, and only the write of the following result waits for the
// receiver to take it
// reset clears the controller and drops m_axis_tvalid_o; the item being worked
// on and a result still waiting in the output register are discarded
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,  // num_a, den_a, num_b, den_b
  input  logic [KIND_BITS-1:0]     s_axis_tuser_i,  // kind
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,  // num_out, den_out
  output logic [0:0]               m_axis_tuser_o   // status
);

  rau_cmd_t                       cmd;
  rau_status_t                    stat;
  logic signed [NUM_OUT_BITS-1:0] num_out;
  logic [DEN_OUT_BITS-1:0]        den_out;
  logic                           status_out;

  rau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (stat),
    .cmd_o     (cmd)
  );

  rau_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (stat),
    .kind_i       (s_axis_tuser_i),
    .num_a_i      (s_axis_tdata_i[OPERAND_BITS-1:0]),
    .den_a_i      (s_axis_tdata_i[2*OPERAND_BITS-1:OPERAND_BITS]),
    .num_b_i      (s_axis_tdata_i[3*OPERAND_BITS-1:2*OPERAND_BITS]),
    .den_b_i      (s_axis_tdata_i[4*OPERAND_BITS-1:3*OPERAND_BITS]),
    .num_out_o    (num_out),
    .den_out_o    (den_out),
    .status_out_o (status_out)
  );

  assign m_axis_tdata_o = OUT_DATA_BITS'({den_out, num_out});
  assign m_axis_tuser_o = status_out;

  // error results carry 0/0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_out) |-> (num_out == '0 && den_out == '0))
    else $error("error item with nonzero payload");

  // a good result never has a zero denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !status_out) |-> (den_out != '0))
    else $error("zero denominator on a good item");

  // zero is always given as 0/1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !status_out && num_out == '0) |-> (den_out == DEN_OUT_BITS'(1)))
    else $error("zero result not in lowest terms");

  // the unit is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while busy");

endmodule
